@@ sv/bba_pkg.sv @@
// bba_pkg: shared types, codes and constants of the bitmap block allocator
// depends on nothing; used by bba_byte_unit, bitmap_block_allocator and the testbench
`timescale 1ns / 1ps

package bba_pkg;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_SIZE = 2'd1,
        ACT_TAKE = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    // result codes carried in m_tuser
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_BIG  = 2'd1,
        STATUS_NO_SPACE = 2'd2,
        STATUS_NONE     = 2'd3
    } status_t;

    // what the shared byte unit reports about one bitmap byte
    typedef struct packed {
        logic [3:0] zeros;     // number of free blocks in the byte
        logic       found;     // at least one free block
        logic [2:0] pos;       // first free block counted from the msb
        logic [7:0] set_byte;  // byte with that block marked used
    } byte_info_t;

    localparam int COUNT_W   = 19;
    localparam int NEEDED_W  = 13;
    localparam int BLOCK_W   = 19;
    localparam int IDX_W     = 15;
    localparam int TDATA_W   = 56;

    localparam int          BLOCK_SHIFT  = 12;          // 4 KiB blocks
    localparam logic [31:0] SMALL_LIMIT  = 32'd28672;
    localparam logic [31:0] BIG_LIMIT    = 32'd29360128;
    localparam logic [NEEDED_W-1:0] INDEX_BLOCKS = 13'd7;
    localparam logic [NEEDED_W-1:0] MAX_NEEDED   = 13'd7175;
    localparam int          SCAN_LIMIT   = 32640;
    localparam int          COUNT_MAX    = 524287;

endpackage

@@ sv/bba_ram.sv @@
// bba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/bba_byte_unit.sv @@
// bba_byte_unit: shared byte evaluator for free counting and first-fit search
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_byte_unit (
    input  logic [7:0]          byte_in,
    output bba_pkg::byte_info_t info
);

    always_comb begin
        logic [3:0] cnt;
        logic       hit;
        logic [2:0] pos;
        cnt = 4'd0;
        hit = 1'b0;
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + {3'd0, ~byte_in[i]};
        end
        // most significant block first
        for (int j = 0; j < 8; j++) begin
            if (!hit && !byte_in[7-j]) begin
                hit = 1'b1;
                pos = 3'(j);
            end
        end
        info.zeros    = cnt;
        info.found    = hit;
        info.pos      = pos;
        info.set_byte = byte_in | (8'h80 >> pos);
    end

endmodule

@@ sv/bitmap_block_allocator.sv @@
// bitmap_block_allocator: first-fit block allocator over a free-block bitmap
// after reset the bitmap ram is cleared one byte a cycle, all BITMAP_BYTES bytes, s_tready low
// load: read old byte, write, respond; an index past the bitmap goes straight to respond
// size: return reservation, judge, respond; nop and take with nothing reserved: respond
// take: one bitmap byte examined per cycle through the ram read port, over at most the
// first min(32640, BITMAP_BYTES) bytes; one request in flight at a time
// depends on bba_pkg, bba_ram, bba_byte_unit
`timescale 1ns / 1ps

module bitmap_block_allocator #(
    parameter int BITMAP_BYTES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // byte_index[14:0], byte_value[22:15], file_size[54:23]
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // blocks_needed[12:0], block_number[31:13], free_blocks[50:32]
    output logic [1:0]  m_tuser,  // status[1:0]
    output logic        m_tlast
);

    localparam int AW         = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int SCAN_BYTES = (bba_pkg::SCAN_LIMIT < BITMAP_BYTES) ?
                                bba_pkg::SCAN_LIMIT : BITMAP_BYTES;
    localparam int CAP_INT    = (BITMAP_BYTES * 8 > bba_pkg::COUNT_MAX) ?
                                bba_pkg::COUNT_MAX : BITMAP_BYTES * 8;
    localparam logic [bba_pkg::COUNT_W:0] FREE_CAP = (bba_pkg::COUNT_W+1)'(CAP_INT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SIZE_REL,
        ST_SIZE_JUDGE,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t state_reg;

    // request fields
    logic [bba_pkg::IDX_W-1:0] in_idx;
    logic [7:0]                in_val;
    logic [31:0]               in_size;
    bba_pkg::action_t          in_action;
    logic [16:0]               idx_wide;
    logic                      idx_ok;
    logic                      accept;

    assign in_idx    = s_tdata[14:0];
    assign in_val    = s_tdata[22:15];
    assign in_size   = s_tdata[54:23];
    assign in_action = bba_pkg::action_t'(s_tuser);
    assign idx_wide  = {2'd0, in_idx};
    assign idx_ok    = idx_wide < 17'(BITMAP_BYTES);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // allocator state
    logic [bba_pkg::COUNT_W-1:0]  free_reg;
    logic [bba_pkg::NEEDED_W-1:0] pending_reg;

    // per-request working registers and the clear counter
    logic [AW-1:0]                clr_cnt_reg;
    logic [AW-1:0]                load_addr_reg;
    logic [7:0]                   load_val_reg;
    logic [3:0]                   newz_reg;
    logic [31:0]                  size_reg;
    logic                         too_big_reg;
    logic [bba_pkg::NEEDED_W-1:0] needed_reg;
    logic [AW:0]                  scan_cnt_reg;
    logic [AW-1:0]                eval_addr_reg;
    logic                         eval_valid_reg;

    // result waiting for the output register
    bba_pkg::status_t             res_status_reg;
    logic [bba_pkg::NEEDED_W-1:0] res_needed_reg;
    logic [bba_pkg::BLOCK_W-1:0]  res_block_reg;
    logic                         res_last_reg;

    // output register
    logic                         m_tvalid_reg;
    logic [55:0]                  m_tdata_reg;
    logic [1:0]                   m_tuser_reg;
    logic                         m_tlast_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // bitmap ram and shared byte unit
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_data;
    logic [7:0]          unit_byte;
    bba_pkg::byte_info_t info;

    bba_ram #(
        .WIDTH (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bba_byte_unit u_unit (
        .byte_in (unit_byte),
        .info    (info)
    );

    logic scan_issue;
    logic scan_hit;
    logic scan_miss;

    assign scan_issue = scan_cnt_reg < (AW+1)'(SCAN_BYTES);
    assign scan_hit   = eval_valid_reg && info.found;
    assign scan_miss  = eval_valid_reg && !info.found &&
                        (eval_addr_reg == AW'(SCAN_BYTES - 1));

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = load_addr_reg;
        wr_data   = load_val_reg;
        rd_en     = 1'b0;
        rd_addr   = idx_wide[AW-1:0];
        unit_byte = rd_data;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = 8'd0;
            end
            ST_IDLE: begin
                unit_byte = in_val;
                rd_en     = accept && (in_action == bba_pkg::ACT_LOAD) && idx_ok;
            end
            ST_LOAD: begin
                wr_en = 1'b1;
            end
            ST_SCAN: begin
                rd_en   = scan_issue;
                rd_addr = scan_cnt_reg[AW-1:0];
                wr_en   = scan_hit;
                wr_addr = eval_addr_reg;
                wr_data = info.set_byte;
            end
            default: begin
            end
        endcase
    end

    // free count after a load, saturating at zero and at the cap
    logic [bba_pkg::COUNT_W-1:0] load_free;
    logic [bba_pkg::COUNT_W:0]   load_sum;
    logic [3:0]                  load_down;

    always_comb begin
        load_sum  = {1'b0, free_reg} + (bba_pkg::COUNT_W+1)'(newz_reg - info.zeros);
        load_down = info.zeros - newz_reg;
        if (newz_reg >= info.zeros) begin
            load_free = (load_sum > FREE_CAP) ? FREE_CAP[bba_pkg::COUNT_W-1:0]
                                              : load_sum[bba_pkg::COUNT_W-1:0];
        end else begin
            load_free = (free_reg > bba_pkg::COUNT_W'(load_down)) ?
                        free_reg - bba_pkg::COUNT_W'(load_down) : '0;
        end
    end

    // unclaimed reservation returned to the free count, and blocks needed for the size
    logic [bba_pkg::COUNT_W:0]    rel_sum;
    logic [bba_pkg::NEEDED_W-1:0] size_blocks;

    assign rel_sum     = {1'b0, free_reg} + (bba_pkg::COUNT_W+1)'(pending_reg);
    assign size_blocks = size_reg[bba_pkg::BLOCK_SHIFT +: bba_pkg::NEEDED_W]
                       + bba_pkg::NEEDED_W'(|size_reg[bba_pkg::BLOCK_SHIFT-1:0])
                       + ((size_reg > bba_pkg::SMALL_LIMIT) ? bba_pkg::INDEX_BLOCKS : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            free_reg       <= FREE_CAP[bba_pkg::COUNT_W-1:0];
            pending_reg    <= '0;
            eval_valid_reg <= 1'b0;
            scan_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // the response state loads the output register itself
            if (m_tready && state_reg != ST_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(BITMAP_BYTES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        res_needed_reg <= '0;
                        res_block_reg  <= '0;
                        res_last_reg   <= 1'b0;
                        load_addr_reg  <= idx_wide[AW-1:0];
                        load_val_reg   <= in_val;
                        newz_reg       <= info.zeros;
                        size_reg       <= in_size;
                        too_big_reg    <= in_size > bba_pkg::BIG_LIMIT;
                        case (in_action)
                            bba_pkg::ACT_LOAD: begin
                                res_status_reg <= bba_pkg::STATUS_OK;
                                state_reg      <= idx_ok ? ST_LOAD : ST_RESP;
                            end
                            bba_pkg::ACT_SIZE: begin
                                res_status_reg <= bba_pkg::STATUS_OK;
                                state_reg      <= ST_SIZE_REL;
                            end
                            bba_pkg::ACT_TAKE: begin
                                if (pending_reg == '0) begin
                                    res_status_reg <= bba_pkg::STATUS_NONE;
                                    state_reg      <= ST_RESP;
                                end else begin
                                    res_status_reg <= bba_pkg::STATUS_OK;
                                    scan_cnt_reg   <= '0;
                                    eval_valid_reg <= 1'b0;
                                    state_reg      <= ST_SCAN;
                                end
                            end
                            default: begin
                                res_status_reg <= bba_pkg::STATUS_NONE;
                                state_reg      <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    free_reg  <= load_free;
                    state_reg <= ST_RESP;
                end
                ST_SIZE_REL: begin
                    free_reg    <= (rel_sum > FREE_CAP) ? FREE_CAP[bba_pkg::COUNT_W-1:0]
                                                        : rel_sum[bba_pkg::COUNT_W-1:0];
                    pending_reg <= '0;
                    needed_reg  <= size_blocks;
                    state_reg   <= ST_SIZE_JUDGE;
                end
                ST_SIZE_JUDGE: begin
                    if (too_big_reg) begin
                        res_status_reg <= bba_pkg::STATUS_TOO_BIG;
                    end else begin
                        res_needed_reg <= needed_reg;
                        if (bba_pkg::COUNT_W'(needed_reg) > free_reg) begin
                            res_status_reg <= bba_pkg::STATUS_NO_SPACE;
                        end else begin
                            free_reg    <= free_reg - bba_pkg::COUNT_W'(needed_reg);
                            pending_reg <= needed_reg;
                        end
                    end
                    state_reg <= ST_RESP;
                end
                ST_SCAN: begin
                    if (scan_issue) begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    eval_valid_reg <= scan_issue && !scan_hit && !scan_miss;
                    eval_addr_reg  <= scan_cnt_reg[AW-1:0];
                    if (scan_hit) begin
                        res_block_reg  <= bba_pkg::BLOCK_W'({eval_addr_reg, info.pos})
                                        + bba_pkg::BLOCK_W'(1);
                        res_last_reg   <= (pending_reg == bba_pkg::NEEDED_W'(1));
                        pending_reg    <= pending_reg - 1'b1;
                        state_reg      <= ST_RESP;
                    end else if (scan_miss) begin
                        res_status_reg <= bba_pkg::STATUS_NO_SPACE;
                        state_reg      <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, free_reg, res_block_reg, res_needed_reg};
                        m_tuser_reg  <= res_status_reg;
                        m_tlast_reg  <= res_last_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_free_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, free_reg} <= FREE_CAP)
        else $error("free count above bitmap capacity");

    a_pending_max: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= bba_pkg::MAX_NEEDED)
        else $error("reservation larger than any legal request");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("bitmap read and write hit the same byte");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= (AW+1)'(SCAN_BYTES)))
        else $error("search ran past the scan window");

    a_take_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && scan_hit) |=> (pending_reg == $past(pending_reg) - 1'b1))
        else $error("claimed block not taken from the reservation");
`endif

endmodule

@@ dv/tb_bitmap_block_allocator.sv @@
// tb_bitmap_block_allocator: self-checking bench for the bitmap block allocator
// a scoreboard class predicts every request and checks each result field by field
// depends on bba_pkg and the bitmap_block_allocator rtl
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;

    localparam int BITMAP_BYTES = 32768;
    localparam int unsigned FREE_CAP =
        (BITMAP_BYTES * 8 > bba_pkg::COUNT_MAX) ? bba_pkg::COUNT_MAX : BITMAP_BYTES * 8;
    localparam int SCAN_BYTES =
        (bba_pkg::SCAN_LIMIT < BITMAP_BYTES) ? bba_pkg::SCAN_LIMIT : BITMAP_BYTES;
    localparam int STALL_LIMIT = 150000;   // clearing pass plus a full-window scan, with margin
    localparam int LONG_HOLD = 200;
    localparam int END_CYCLES = 50;

    typedef struct packed {
        bba_pkg::status_t             status;
        logic [bba_pkg::NEEDED_W-1:0] needed;
        logic [bba_pkg::BLOCK_W-1:0]  block;
        logic                         last;
        logic [bba_pkg::COUNT_W-1:0]  free;
    } alloc_result_t;

    class allocator_scoreboard;
        bit [7:0]      bitmap [BITMAP_BYTES];
        int unsigned   free_count;
        int unsigned   reserved;
        int            failures;
        alloc_result_t due_results [$];

        function new();
            foreach (bitmap[i]) bitmap[i] = 8'h00;
            free_count = FREE_CAP;
            reserved   = 0;
            failures   = 0;
        endfunction

        // free count moves up first, saturating at the cap, then down to zero
        function int unsigned clamp_free(int unsigned base, int unsigned up,
                                         int unsigned down);
            int unsigned v;
            v = base + up;
            if (v > FREE_CAP) v = FREE_CAP;
            return (v > down) ? v - down : 0;
        endfunction

        function alloc_result_t predict_allocation(bba_pkg::action_t act,
                                                   logic [bba_pkg::IDX_W-1:0] idx,
                                                   logic [7:0] val, logic [31:0] size);
            alloc_result_t r;
            int unsigned   old_z, new_z, want;
            int            i, b;
            bit            hit;
            r.status = bba_pkg::STATUS_OK;
            r.needed = '0;
            r.block  = '0;
            r.last   = 1'b0;
            case (act)
                bba_pkg::ACT_LOAD: begin
                    if (idx < BITMAP_BYTES) begin
                        old_z = 8 - $countones(bitmap[idx]);
                        new_z = 8 - $countones(val);
                        bitmap[idx] = val;
                        if (new_z >= old_z)
                            free_count = clamp_free(free_count, new_z - old_z, 0);
                        else
                            free_count = clamp_free(free_count, 0, old_z - new_z);
                    end
                end
                bba_pkg::ACT_SIZE: begin
                    // any earlier reservation is handed back before judging
                    free_count = clamp_free(free_count, reserved, 0);
                    reserved = 0;
                    if (size > bba_pkg::BIG_LIMIT) begin
                        r.status = bba_pkg::STATUS_TOO_BIG;
                    end else begin
                        want = size >> bba_pkg::BLOCK_SHIFT;
                        if (size[bba_pkg::BLOCK_SHIFT-1:0] != '0) want++;
                        if (size > bba_pkg::SMALL_LIMIT) want += bba_pkg::INDEX_BLOCKS;
                        r.needed = bba_pkg::NEEDED_W'(want);
                        if (want > free_count) begin
                            r.status = bba_pkg::STATUS_NO_SPACE;
                        end else begin
                            free_count -= want;
                            reserved = want;
                        end
                    end
                end
                bba_pkg::ACT_TAKE: begin
                    if (reserved == 0) begin
                        r.status = bba_pkg::STATUS_NONE;
                    end else begin
                        hit = 1'b0;
                        for (i = 0; i < SCAN_BYTES && !hit; i++) begin
                            if (bitmap[i] != 8'hFF) begin
                                for (b = 7; b >= 0 && !hit; b--) begin
                                    if (!bitmap[i][b]) begin
                                        bitmap[i][b] = 1'b1;
                                        r.block = bba_pkg::BLOCK_W'(i * 8 + 8 - b);
                                        hit = 1'b1;
                                    end
                                end
                            end
                        end
                        if (hit) begin
                            reserved--;
                            r.last = (reserved == 0);
                        end else begin
                            r.status = bba_pkg::STATUS_NO_SPACE;
                        end
                    end
                end
                default: r.status = bba_pkg::STATUS_NONE;
            endcase
            r.free = bba_pkg::COUNT_W'(free_count);
            return r;
        endfunction

        function void note_request(bba_pkg::action_t act, logic [bba_pkg::IDX_W-1:0] idx,
                                   logic [7:0] val, logic [31:0] size);
            due_results.push_back(predict_allocation(act, idx, val, size));
        endfunction

        function void check_result(bba_pkg::status_t st,
                                   logic [bba_pkg::NEEDED_W-1:0] needed,
                                   logic [bba_pkg::BLOCK_W-1:0] block, logic last,
                                   logic [bba_pkg::COUNT_W-1:0] free);
            alloc_result_t exp;
            if (due_results.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            exp = due_results.pop_front();
            if (st !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, st);
                failures++;
            end
            if (needed !== exp.needed) begin
                $error("blocks_needed: expected %0d, got %0d", exp.needed, needed);
                failures++;
            end
            if (block !== exp.block) begin
                $error("block_number: expected %0d, got %0d", exp.block, block);
                failures++;
            end
            if (last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, last);
                failures++;
            end
            if (free !== exp.free) begin
                $error("free_blocks: expected %0d, got %0d", exp.free, free);
                failures++;
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;  // byte_index[14:0], byte_value[22:15], file_size[54:23]
    logic [1:0]  s_tuser = bba_pkg::ACT_NOP;  // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;  // blocks_needed[12:0], block_number[31:13], free_blocks[50:32]
    logic [1:0]  m_tuser;  // status[1:0]
    logic        m_tlast;

    allocator_scoreboard board = new();
    bit no_idle = 1'b0;
    bit hold_results = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    bitmap_block_allocator #(
        .BITMAP_BYTES(BITMAP_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid === 1'b1 && s_tready === 1'b1)
            board.note_request(bba_pkg::action_t'(s_tuser), s_tdata[14:0], s_tdata[22:15],
                               s_tdata[54:23]);
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1)
            board.check_result(bba_pkg::status_t'(m_tuser), m_tdata[12:0], m_tdata[31:13],
                               m_tlast, m_tdata[50:32]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random back-pressure, with one long hold on request
    initial begin
        int gap;
        forever begin
            if (hold_results) begin
                gap = LONG_HOLD;
                hold_results = 1'b0;
            end else if (no_idle) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 4);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    task automatic send_request(input bba_pkg::action_t act,
                                input logic [bba_pkg::IDX_W-1:0] idx,
                                input logic [7:0] val, input logic [31:0] size);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, size, val, idx};
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.outstanding() != 0);
    endtask

    function automatic logic [bba_pkg::IDX_W-1:0] draw_index();
        // mostly the low bytes, so loads and takes meet each other
        if ($urandom_range(0, 9) < 7)
            return bba_pkg::IDX_W'($urandom_range(0, 15));
        return bba_pkg::IDX_W'($urandom_range(0, BITMAP_BYTES - 1));
    endfunction

    function automatic logic [31:0] draw_file_size();
        case ($urandom_range(0, 6))
            0: return $urandom_range(1, 3 * 4096);
            1: return $urandom_range(0, 8 * 4096);
            2: return ($urandom_range(0, 12) << bba_pkg::BLOCK_SHIFT) + $urandom_range(0, 2) - 1;
            3: return bba_pkg::SMALL_LIMIT - 1 + $urandom_range(0, 2);
            4: return bba_pkg::BIG_LIMIT - 1 + $urandom_range(0, 2);
            5: return $urandom_range(0, bba_pkg::BIG_LIMIT);
            default: return $urandom;
        endcase
    endfunction

    task automatic directed_phase();
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);     // nothing reserved yet
        send_request(bba_pkg::ACT_NOP, 15'h7FFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, 32'd0);     // zero length reserves nothing
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, 32'd1);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, 32'd4096);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, 32'd4097);  // replaces the open reservation
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, bba_pkg::SMALL_LIMIT);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, bba_pkg::SMALL_LIMIT + 32'd1);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, bba_pkg::BIG_LIMIT);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, bba_pkg::BIG_LIMIT + 32'd1);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);     // rejection dropped the reservation
        send_request(bba_pkg::ACT_SIZE, 15'h7FFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(bba_pkg::ACT_LOAD, 15'd0, 8'hFF, 32'd0);
        send_request(bba_pkg::ACT_LOAD, 15'd1, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_LOAD, 15'd2, 8'h7F, 32'd0);
        send_request(bba_pkg::ACT_LOAD, 15'h7FFF, 8'hAA, 32'hFFFF_FFFF);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, 32'd8192);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
    endtask

    // a short run of loads, reservations and takes back to back
    task automatic sweep_phase();
        no_idle = 1'b1;
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, 32'd12288);
        send_request(bba_pkg::ACT_LOAD, 15'd3, 8'hFF, 32'd0);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        // free bits above the scan window are never claimed
        send_request(bba_pkg::ACT_LOAD, bba_pkg::IDX_W'(BITMAP_BYTES - 1), 8'h0F, 32'd0);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_LOAD, bba_pkg::IDX_W'(BITMAP_BYTES - 1), 8'hFF, 32'd0);
        send_request(bba_pkg::ACT_LOAD, 15'd3, 8'h00, 32'd0);
        send_request(bba_pkg::ACT_SIZE, '0, 8'h00, bba_pkg::BIG_LIMIT);
        send_request(bba_pkg::ACT_TAKE, '0, 8'h00, 32'd0);
        no_idle = 1'b0;
    endtask

    task automatic random_phase(input int count);
        int stop_at, takes, k;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                // a reservation and a run of takes, a load slipped in now and then
                send_request(bba_pkg::ACT_SIZE, draw_index(), 8'($urandom), draw_file_size());
                takes = $urandom_range(1, 5);
                for (k = 0; k < takes; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        send_request(bba_pkg::ACT_LOAD, draw_index(), 8'($urandom), $urandom);
                    send_request(bba_pkg::ACT_TAKE, draw_index(), 8'($urandom), $urandom);
                end
            end else begin
                send_request(bba_pkg::action_t'($urandom_range(0, 3)), draw_index(),
                             8'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        directed_phase();
        sweep_phase();
        random_phase(25);
        // quiet pause, then back-pressure while requests keep coming
        drain_results();
        hold_results = 1'b1;
        send_request(bba_pkg::ACT_SIZE, draw_index(), 8'($urandom), 32'd16384);
        send_request(bba_pkg::ACT_TAKE, draw_index(), 8'($urandom), $urandom);
        send_request(bba_pkg::ACT_TAKE, draw_index(), 8'($urandom), $urandom);
        send_request(bba_pkg::ACT_LOAD, draw_index(), 8'($urandom), $urandom);
        send_request(bba_pkg::ACT_TAKE, draw_index(), 8'($urandom), $urandom);
        random_phase(25);
        drain_results();
        repeat (END_CYCLES) @(posedge aclk);
        if (board.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
